>>> rtl/core/fpt_pkg.sv
// Shared types and constants for the four-level page table manager.
package fpt_pkg;

    localparam int IDX_W = 9;
    localparam int UE_W  = 49;

    localparam logic [1:0] REQ_MAP   = 2'd0;
    localparam logic [1:0] REQ_UNMAP = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_INVALID = 3'd1;
    localparam logic [2:0] STS_PERM    = 3'd2;
    localparam logic [2:0] STS_NO_TBL  = 3'd3;
    localparam logic [2:0] STS_MAPPED  = 3'd4;

    localparam logic [1:0] CFG_NX_ENABLE = 2'd0;
    localparam logic [1:0] CFG_USER_END  = 2'd1;

    localparam logic [63:0] PAGE_BYTES = 64'd4096;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] virt_addr;
        logic [63:0] phys_addr;
        logic        flag_write;
        logic        flag_user;
        logic        flag_write_through;
        logic        flag_cache_disable;
        logic        flag_global;
        logic        flag_no_exec;
        logic [20:0] length;
        logic        check_write;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       range_ok;
        logic       tlb_invalidate;
    } rsp_t;

    typedef struct packed {
        logic            nx_enable;
        logic [UE_W-1:0] user_va_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VAL,
        ST_LIM,
        ST_PCMP,
        ST_RD,
        ST_EV,
        ST_STEP
    } ctl_state_t;

endpackage

>>> rtl/core/fpt_alu.sv
// Shared 64-bit adder and unsigned comparator.
module fpt_alu
    import fpt_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [64:0] sum,
    output logic        lt
);

    assign sum = {1'b0, a} + {1'b0, b};
    assign lt  = a < b;

endmodule

>>> rtl/core/fpt_ram.sv
// Single-write, single-read table store with registered read data.
module fpt_ram
    import fpt_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/fpt_ctrl.sv
// Request sequencer: validation, table walk, range scan and result register.
module fpt_ctrl
    import fpt_pkg::*;
#(
    parameter int POOL_TABLES     = 16,
    parameter int MAX_CHECK_BYTES = 1048576
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_item,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_item
);

    localparam int TBL_W = $clog2(POOL_TABLES);
    localparam int CNT_W = $clog2(POOL_TABLES + 1);
    localparam int AW    = TBL_W + IDX_W;
    localparam int DEPTH = POOL_TABLES * 512;

    ctl_state_t         state_reg, state_next;
    req_t               req_reg, req_next;
    rsp_t               res_reg, res_next;
    rsp_t               m_item_reg, m_item_next;
    logic               m_valid_reg, m_valid_next;
    logic [TBL_W-1:0]   tbl_reg, tbl_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [63:0]        page_reg, page_next;
    logic [63:0]        end_reg, end_next;
    logic               wrap_reg, wrap_next;
    logic               done;

    logic [63:0] alu_a, alu_b;
    logic [64:0] alu_sum;
    logic        alu_lt;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    fpt_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    fpt_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // level index of the address being walked
    logic [IDX_W-1:0] idx;
    always_comb begin
        case (lvl_reg)
            2'd0:    idx = page_reg[47:39];
            2'd1:    idx = page_reg[38:30];
            2'd2:    idx = page_reg[29:21];
            default: idx = page_reg[20:12];
        endcase
    end

    logic is_map, is_unmap, is_check, last, full;
    logic e_p, e_rw, e_us, child_ok, chk_pass, ev_desc;
    logic canon, addr_bad, map_bad, map_perm, nx_bit;
    logic [63:0] leaf, fresh_ent;

    assign is_map   = req_reg.req_type == REQ_MAP;
    assign is_unmap = req_reg.req_type == REQ_UNMAP;
    assign is_check = req_reg.req_type == REQ_CHECK;
    assign last     = lvl_reg == 2'd3;
    assign full     = used_reg >= CNT_W'(POOL_TABLES);

    assign e_p      = ram_rdata[0];
    assign e_rw     = ram_rdata[1];
    assign e_us     = ram_rdata[2];
    assign child_ok = ram_rdata[51:12] < 40'(POOL_TABLES);
    assign chk_pass = e_p & e_us & (!req_reg.check_write | e_rw) & (last | child_ok);

    always_comb begin
        ev_desc = 1'b0;
        if (!last) begin
            if (is_map) begin
                ev_desc = (e_p & child_ok) | (!e_p & !full);
            end else if (is_unmap) begin
                ev_desc = e_p & child_ok;
            end else begin
                ev_desc = chk_pass;
            end
        end
    end

    assign canon    = (req_reg.virt_addr[63:47] == '0) || (req_reg.virt_addr[63:47] == '1);
    assign addr_bad = (req_reg.virt_addr == '0) || (req_reg.virt_addr[11:0] != '0) ||
                      !canon || !alu_lt;
    assign map_bad  = addr_bad || (req_reg.phys_addr[11:0] != '0) ||
                      (req_reg.phys_addr[63:52] != '0);
    assign nx_bit   = req_reg.flag_no_exec & cfg.nx_enable;
    assign map_perm = cfg.nx_enable & req_reg.flag_write & !nx_bit;

    assign leaf = {nx_bit, 11'b0, req_reg.phys_addr[51:12], 3'b0, req_reg.flag_global,
                   3'b0, req_reg.flag_cache_disable, req_reg.flag_write_through,
                   req_reg.flag_user, req_reg.flag_write, 1'b1};
    assign fresh_ent = (64'(used_reg) << 12) | {61'b0, req_reg.flag_user, 2'b11};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_VAL;
                end
            end
            ST_VAL: begin
                if (is_map) begin
                    state_next = (map_bad || map_perm) ? ST_STEP : ST_RD;
                end else if (is_unmap) begin
                    state_next = addr_bad ? ST_STEP : ST_RD;
                end else if (is_check) begin
                    if (({4'b0, req_reg.length} > 25'(MAX_CHECK_BYTES)) ||
                        (req_reg.length == '0)) begin
                        state_next = ST_STEP;
                    end else begin
                        state_next = ST_LIM;
                    end
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_LIM:  state_next = (wrap_reg || alu_lt) ? ST_STEP : ST_PCMP;
            ST_PCMP: state_next = alu_lt ? ST_RD : ST_STEP;
            ST_RD:   state_next = ST_EV;
            ST_EV: begin
                if (ev_desc) begin
                    state_next = ST_RD;
                end else if (is_check && last && chk_pass) begin
                    state_next = ST_PCMP;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (done && (!m_valid_reg || m_ready)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        req_next     = req_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        tbl_next     = tbl_reg;
        lvl_next     = lvl_reg;
        used_next    = used_reg;
        clr_next     = clr_reg;
        page_next    = page_reg;
        end_next     = end_reg;
        wrap_next    = wrap_reg;
        done         = 1'b1;
        alu_a        = req_reg.virt_addr;
        alu_b        = 64'(cfg.user_va_limit);
        ram_we       = 1'b0;
        ram_waddr    = {tbl_reg, idx};
        ram_wdata    = '0;
        ram_raddr    = {tbl_reg, idx};
        s_ready      = state_reg == ST_IDLE;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_item;
                    res_next = '0;
                end
            end
            ST_VAL: begin
                tbl_next  = '0;
                lvl_next  = '0;
                page_next = req_reg.virt_addr;
                if (is_map) begin
                    if (map_bad) begin
                        res_next.status = STS_INVALID;
                    end else if (map_perm) begin
                        res_next.status = STS_PERM;
                    end
                end else if (is_unmap) begin
                    if (addr_bad) begin
                        res_next.status = STS_INVALID;
                    end
                end else if (is_check) begin
                    alu_b     = 64'(req_reg.length);
                    end_next  = alu_sum[63:0];
                    wrap_next = alu_sum[64];
                    if ({4'b0, req_reg.length} > 25'(MAX_CHECK_BYTES)) begin
                        res_next.status = STS_INVALID;
                    end else if (req_reg.length == '0) begin
                        res_next.range_ok = 1'b1;
                    end
                end else begin
                    res_next.status = STS_INVALID;
                end
            end
            ST_LIM: begin
                alu_a     = 64'(cfg.user_va_limit);
                alu_b     = end_reg;
                page_next = {req_reg.virt_addr[63:12], 12'b0};
            end
            ST_PCMP: begin
                alu_a    = page_reg;
                alu_b    = end_reg;
                tbl_next = '0;
                lvl_next = '0;
                if (!alu_lt) begin
                    res_next.range_ok = 1'b1;
                end
            end
            ST_EV: begin
                if (ev_desc) begin
                    lvl_next = lvl_reg + 2'd1;
                    if (is_map && !e_p) begin
                        ram_we    = 1'b1;
                        ram_wdata = fresh_ent;
                        used_next = used_reg + CNT_W'(1);
                        tbl_next  = used_reg[TBL_W-1:0];
                    end else begin
                        tbl_next = ram_rdata[TBL_W+11:12];
                        if (is_map && req_reg.flag_user && !e_us) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | 64'h4;
                        end
                    end
                end else if (is_map) begin
                    if (!last) begin
                        res_next.status = STS_NO_TBL;
                    end else if (e_p) begin
                        res_next.status = STS_MAPPED;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = leaf;
                        res_next.tlb_invalidate = 1'b1;
                    end
                end else if (is_unmap) begin
                    if (last && e_p) begin
                        ram_we = 1'b1;
                        res_next.tlb_invalidate = 1'b1;
                    end else begin
                        res_next.status = STS_INVALID;
                    end
                end else if (last && chk_pass) begin
                    alu_a     = page_reg;
                    alu_b     = PAGE_BYTES;
                    page_next = alu_sum[63:0];
                end
            end
            ST_STEP: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: done = 1'b0;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            used_reg    <= CNT_W'(1);
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            used_reg    <= used_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
        tbl_reg    <= tbl_next;
        lvl_reg    <= lvl_next;
        page_reg   <= page_next;
        end_reg    <= end_next;
        wrap_reg   <= wrap_next;
    end

endmodule

>>> rtl/core/four_level_page_table_manager.sv
// Top level of the four-level page table manager: config registers and sequencer.
//
// Usage:
//  - s_ channel takes one request item (map, unmap, range check) per handshake;
//    m_ channel returns exactly one result item per request, in order.
//  - cfg_ channel writes nx_enable (index 0) or the user address limit (index 1);
//    other indexes are ignored. cfg_ready is always high; write only when idle.
//  - One request at a time: s_ready is high only while the sequencer is idle.
//  - Each request passes validation and then, if accepted, a table walk
//    through the table store (one read and one write port), each level a
//    read, then an evaluate/update step; a range check walks the pages
//    touched in turn, and rejected arguments skip the walk.
//  - The result sits in an output register; the sequencer may take the next
//    request while a result waits, but holds its own result until the
//    previous one has been taken when m_ready stays low.
//  - After reset the whole table store (POOL_TABLES * 512 entries) is swept to
//    zero, one entry per cycle; no request is taken during that pass. Config
//    writes are accepted throughout.
module four_level_page_table_manager
    import fpt_pkg::*;
#(
    parameter int POOL_TABLES     = 16,
    parameter int MAX_CHECK_BYTES = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    // config registers, reset to NX on and a 128 TiB user space
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nx_enable     <= 1'b1;
            cfg_reg.user_va_limit <= UE_W'(49'h0_8000_0000_0000);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NX_ENABLE: cfg_reg.nx_enable     <= cfg_data[0];
                CFG_USER_END:  cfg_reg.user_va_limit <= cfg_data[UE_W-1:0];
                default: ;
            endcase
        end
    end

    fpt_ctrl #(
        .POOL_TABLES     (POOL_TABLES),
        .MAX_CHECK_BYTES (MAX_CHECK_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the four-level page table manager.
`timescale 1ns / 100ps

module tb;
    import fpt_pkg::*;

    localparam int POOL       = 16;
    localparam int MAX_CHK    = 1048576;
    localparam int ENTRIES    = POOL * 512;
    localparam int CYCLE_CAP  = 10000000;
    localparam int RAND_ITEMS = 550;
    localparam int N_DIR      = 21;

    // request code the block must reject
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam int unsigned NO_CHILD = 32'hFFFF_FFFF;

    // page-entry bits
    localparam logic [63:0] E_P   = 64'h1;
    localparam logic [63:0] E_RW  = 64'h2;
    localparam logic [63:0] E_US  = 64'h4;
    localparam logic [63:0] E_PWT = 64'h8;
    localparam logic [63:0] E_PCD = 64'h10;
    localparam logic [63:0] E_G   = 64'h100;
    localparam logic [63:0] E_NX  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] E_ADR = 64'h000F_FFFF_FFFF_F000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsp_t        m_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    four_level_page_table_manager #(
        .POOL_TABLES(POOL),
        .MAX_CHECK_BYTES(MAX_CHK)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow page tables and config
    // ---------------------------------------------------------------
    logic [63:0]     shadow_tbl [0:ENTRIES-1];
    int unsigned     shadow_used;
    logic            shadow_nx;
    logic [UE_W-1:0] shadow_uend;

    rsp_t pending_rsp [$];
    int   fail_cnt = 0;
    int   rsp_cnt = 0;
    int   ok_maps = 0;
    int   ok_ranges = 0;
    int   burst_left = 0;

    function automatic logic [63:0] ent_rd(int unsigned t, logic [8:0] idx);
        if (t >= POOL) return 64'd0;
        return shadow_tbl[t * 512 + idx];
    endfunction

    function automatic void ent_wr(int unsigned t, logic [8:0] idx, logic [63:0] v);
        if (t < POOL) shadow_tbl[t * 512 + idx] = v;
    endfunction

    function automatic logic [8:0] lvl_sel(logic [63:0] va, int lvl);
        return va[47 - 9 * lvl -: 9];
    endfunction

    // follow one level; allocate a zeroed table on a miss when asked
    function automatic int unsigned next_table(int unsigned t, logic [8:0] idx,
                                               bit create, bit user);
        logic [63:0] e;
        logic [63:0] child;
        int unsigned fresh;
        e = ent_rd(t, idx);
        if (e & E_P) begin
            child = (e & E_ADR) >> 12;
            if (child >= POOL) return NO_CHILD;
            if (user && !(e & E_US)) ent_wr(t, idx, e | E_US);
            return child[31:0];
        end
        if (!create || shadow_used >= POOL) return NO_CHILD;
        fresh = shadow_used++;
        for (int i = 0; i < 512; i++) shadow_tbl[fresh * 512 + i] = 64'd0;
        ent_wr(t, idx, (64'(fresh) << 12) | E_P | E_RW | (user ? E_US : 64'd0));
        return fresh;
    endfunction

    function automatic bit va_usable(logic [63:0] va);
        bit canon;
        canon = (va[63:47] == '0) || (va[63:47] == '1);
        return va != 0 && va[11:0] == 0 && canon && va < {15'd0, shadow_uend};
    endfunction

    function automatic logic [2:0] shadow_map(req_t r);
        logic [63:0] fl;
        int unsigned t;
        if (r.phys_addr[11:0] != 0 || !va_usable(r.virt_addr) || r.phys_addr[63:52] != 0)
            return STS_INVALID;
        fl = 64'd0;
        if (r.flag_write) fl |= E_RW;
        if (r.flag_user) fl |= E_US;
        if (r.flag_write_through) fl |= E_PWT;
        if (r.flag_cache_disable) fl |= E_PCD;
        if (r.flag_global) fl |= E_G;
        if (r.flag_no_exec && shadow_nx) fl |= E_NX;
        if (shadow_nx && (fl & E_RW) && !(fl & E_NX)) return STS_PERM;
        t = 0;
        for (int l = 0; l < 3; l++) begin
            t = next_table(t, lvl_sel(r.virt_addr, l), 1'b1, r.flag_user);
            if (t == NO_CHILD) return STS_NO_TBL;
        end
        if (ent_rd(t, lvl_sel(r.virt_addr, 3)) & E_P) return STS_MAPPED;
        ent_wr(t, lvl_sel(r.virt_addr, 3), r.phys_addr | fl | E_P);
        return STS_OK;
    endfunction

    function automatic logic [2:0] shadow_unmap(logic [63:0] va);
        int unsigned t;
        if (!va_usable(va)) return STS_INVALID;
        t = 0;
        for (int l = 0; l < 3; l++) begin
            t = next_table(t, lvl_sel(va, l), 1'b0, 1'b0);
            if (t == NO_CHILD) return STS_INVALID;
        end
        if (!(ent_rd(t, lvl_sel(va, 3)) & E_P)) return STS_INVALID;
        ent_wr(t, lvl_sel(va, 3), 64'd0);
        return STS_OK;
    endfunction

    function automatic bit page_allowed(logic [63:0] va, bit wr);
        int unsigned t;
        logic [63:0] e;
        t = 0;
        for (int l = 0; l < 4; l++) begin
            e = ent_rd(t, lvl_sel(va, l));
            if (!(e & E_P) || !(e & E_US)) return 1'b0;
            if (wr && !(e & E_RW)) return 1'b0;
            if (l < 3) begin
                if (((e & E_ADR) >> 12) >= POOL) return 1'b0;
                t = 32'((e & E_ADR) >> 12);
            end
        end
        return 1'b1;
    endfunction

    function automatic bit range_allowed(logic [63:0] start, logic [20:0] len, bit wr);
        logic [64:0] stop;
        logic [63:0] pg;
        if (len == 0) return 1'b1;
        stop = {1'b0, start} + 65'(len);
        if (stop[64] || stop[63:0] > {15'd0, shadow_uend}) return 1'b0;
        for (pg = {start[63:12], 12'd0}; pg < stop[63:0]; pg += PAGE_BYTES)
            if (!page_allowed(pg, wr)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_rsp(req_t r);
        rsp_t o;
        o = '0;
        o.status = STS_INVALID;
        case (r.req_type)
            REQ_MAP: begin
                o.status = shadow_map(r);
                o.tlb_invalidate = (o.status == STS_OK);
            end
            REQ_UNMAP: begin
                o.status = shadow_unmap(r.virt_addr);
                o.tlb_invalidate = (o.status == STS_OK);
            end
            REQ_CHECK: begin
                if (r.length <= MAX_CHK) begin
                    o.status = STS_OK;
                    o.range_ok = range_allowed(r.virt_addr, r.length, r.check_write);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // override: typed-in expectation replaces the prediction, state still advances
    task automatic send_item(req_t r, bit typed, rsp_t typed_rsp);
        rsp_t p;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_rsp(r);
        if (p.status == STS_OK && r.req_type == REQ_MAP) ok_maps++;
        if (p.range_ok) ok_ranges++;
        pending_rsp.push_back(typed ? typed_rsp : p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_NX_ENABLE) shadow_nx = val[0];
        else if (idx == CFG_USER_END) shadow_uend = val[UE_W-1:0];
    endtask

    function automatic req_t mk_req(logic [1:0] rt, logic [63:0] va, logic [63:0] pa,
                                    logic [5:0] fl, logic [20:0] len, logic cw);
        req_t r;
        r = '0;
        r.req_type = rt;
        r.virt_addr = va;
        r.phys_addr = pa;
        {r.flag_write, r.flag_user, r.flag_write_through,
         r.flag_cache_disable, r.flag_global, r.flag_no_exec} = fl;
        r.length = len;
        r.check_write = cw;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [2:0] st, logic rok);
        rsp_t o;
        o = '0;
        o.status = st;
        o.range_ok = rok;
        return o;
    endfunction

    // addresses in a handful of regions so tables get shared and the pool can run dry
    function automatic logic [63:0] region_va();
        logic [8:0] i4, i3, i2, i1;
        i4 = ($urandom_range(0, 2) == 0) ? 9'd0 : (($urandom_range(0, 1) == 0) ? 9'd1 : 9'd255);
        i3 = $urandom_range(0, 1) ? 9'd511 : 9'd0;
        i2 = $urandom_range(0, 1) ? 9'd3 : 9'd0;
        i1 = 9'($urandom_range(0, 15));
        return {16'd0, i4, i3, i2, i1, 12'd0};
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int k;
        logic [63:0] rnd;
        logic [159:0] noise;
        r = '0;
        k = $urandom_range(0, 99);
        if (k < 35) begin
            r.req_type = REQ_MAP;
            r.virt_addr = region_va();
            r.phys_addr = {$urandom, $urandom} & E_ADR;
            r.flag_write = 1'($urandom_range(0, 1));
            r.flag_user = ($urandom_range(0, 4) != 0);
            r.flag_write_through = 1'($urandom_range(0, 1));
            r.flag_cache_disable = 1'($urandom_range(0, 1));
            r.flag_global = 1'($urandom_range(0, 1));
            r.flag_no_exec = r.flag_write ? ($urandom_range(0, 9) != 0) :
                                            1'($urandom_range(0, 1));
        end else if (k < 50) begin
            r.req_type = REQ_UNMAP;
            r.virt_addr = region_va();
        end else if (k < 82) begin
            r.req_type = REQ_CHECK;
            r.virt_addr = region_va() + 64'($urandom_range(0, 8191));
            r.check_write = 1'($urandom_range(0, 1));
            k = $urandom_range(0, 19);
            if (k == 0) r.length = 21'(MAX_CHK);
            else if (k == 1) r.length = 21'($urandom);
            else r.length = 21'($urandom_range(0, 20000));
        end else begin
            // raw noise over every field
            rnd = {$urandom, $urandom};
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(req_t)-1:0];
            if ($urandom_range(0, 1)) r.virt_addr = rnd;
            if (r.req_type == REQ_CHECK && r.length <= MAX_CHK)
                r.length = 21'(r.length[13:0]);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking and ready pattern
    // ---------------------------------------------------------------
    int unsigned rdy_tick = 0;
    int          rdy_mode = 0;

    always @(posedge aclk) begin
        rsp_t e;
        rdy_tick++;
        if (rdy_tick % 64 == 0) rdy_mode = $urandom_range(0, 3);
        if (aresetn && m_valid && m_ready) begin
            rsp_cnt++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: result with nothing pending: %p", $time, m_item);
                fail_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (m_item.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, m_item.status);
                    fail_cnt++;
                end
                if (m_item.range_ok !== e.range_ok) begin
                    $display("%0t: range_ok exp %0d got %0d", $time, e.range_ok,
                             m_item.range_ok);
                    fail_cnt++;
                end
                if (m_item.tlb_invalidate !== e.tlb_invalidate) begin
                    $display("%0t: tlb_invalidate exp %0d got %0d", $time,
                             e.tlb_invalidate, m_item.tlb_invalidate);
                    fail_cnt++;
                end
            end
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rdy_tick[4:0] == 0);
        endcase
    end

    // run guard
    int unsigned cyc = 0;
    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_CAP) begin
            $display("[four_level_page_table_manager] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        req_t        dir_req [N_DIR];
        bit          dir_typed [N_DIR];
        rsp_t        dir_rsp [N_DIR];
        logic [63:0] ue_set [5];
        logic        nx_set [5];

        for (int i = 0; i < ENTRIES; i++) shadow_tbl[i] = 64'd0;
        shadow_used = 1;
        shadow_nx = 1'b1;
        shadow_uend = 49'h0_8000_0000_0000;

        // directed rows: flags are {RW, US, PWT, PCD, G, NX}
        dir_req[0]  = mk_req(REQ_CHECK, 64'h1000, 64'd0, 6'b0, 21'd0, 1'b0);
        dir_req[1]  = mk_req(REQ_CHECK, 64'h1000, 64'd0, 6'b0, 21'(MAX_CHK + 1), 1'b0);
        dir_req[2]  = mk_req(REQ_BAD, 64'h1000, 64'h2000, 6'b111111, 21'h1FFFFF, 1'b1);
        dir_req[3]  = mk_req(REQ_MAP, 64'h0, 64'h2000, 6'b110001, 21'd0, 1'b0);
        dir_req[4]  = mk_req(REQ_MAP, 64'h1000, 64'h2001, 6'b110001, 21'd0, 1'b0);
        dir_req[5]  = mk_req(REQ_MAP, 64'h0000_8000_0000_0000, 64'h2000, 6'b110001,
                             21'd0, 1'b0);
        dir_req[6]  = mk_req(REQ_MAP, 64'hFFFF_8000_0000_0000, 64'h2000, 6'b110001,
                             21'd0, 1'b0);
        dir_req[7]  = mk_req(REQ_MAP, 64'h1000, 64'h0010_0000_0000_0000, 6'b110001,
                             21'd0, 1'b0);
        dir_req[8]  = mk_req(REQ_MAP, 64'h1000, 64'h2000, 6'b110000, 21'd0, 1'b0);
        dir_req[9]  = mk_req(REQ_UNMAP, 64'h1000, 64'd0, 6'b0, 21'd0, 1'b0);
        dir_req[10] = mk_req(REQ_MAP, 64'h1000, 64'h000F_FFFF_FFFF_F000, 6'b111111,
                             21'd0, 1'b0);
        dir_req[11] = mk_req(REQ_MAP, 64'h1000, 64'h3000, 6'b010000, 21'd0, 1'b0);
        dir_req[12] = mk_req(REQ_CHECK, 64'h1000, 64'd0, 6'b0, 21'd4096, 1'b1);
        dir_req[13] = mk_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_F000, 64'd0, 6'b0, 21'h2000, 1'b0);
        dir_req[14] = mk_req(REQ_CHECK, 64'h7FFF_FFFF_F000, 64'd0, 6'b0, 21'h2000, 1'b0);
        dir_req[15] = mk_req(REQ_CHECK, 64'h1800, 64'd0, 6'b0, 21'h1000, 1'b0);
        dir_req[16] = mk_req(REQ_MAP, 64'h2000, 64'h5000, 6'b000000, 21'd0, 1'b0);
        dir_req[17] = mk_req(REQ_CHECK, 64'h2000, 64'd0, 6'b0, 21'd1, 1'b0);
        dir_req[18] = mk_req(REQ_UNMAP, 64'h1000, 64'd0, 6'b0, 21'd0, 1'b0);
        dir_req[19] = mk_req(REQ_UNMAP, 64'h1000, 64'd0, 6'b0, 21'd0, 1'b0);
        dir_req[20] = mk_req(REQ_UNMAP, 64'h0, 64'd0, 6'b0, 21'd0, 1'b0);
        for (int i = 0; i < N_DIR; i++) dir_typed[i] = 1'b0;
        dir_rsp[0] = mk_rsp(STS_OK, 1'b1);        dir_typed[0] = 1'b1;
        for (int i = 1; i <= 7; i++) begin
            dir_rsp[i] = mk_rsp(STS_INVALID, 1'b0); dir_typed[i] = 1'b1;
        end
        dir_rsp[8]  = mk_rsp(STS_PERM, 1'b0);     dir_typed[8] = 1'b1;
        dir_rsp[9]  = mk_rsp(STS_INVALID, 1'b0);  dir_typed[9] = 1'b1;
        dir_rsp[13] = mk_rsp(STS_OK, 1'b0);       dir_typed[13] = 1'b1;
        dir_rsp[14] = mk_rsp(STS_OK, 1'b0);       dir_typed[14] = 1'b1;
        dir_rsp[19] = mk_rsp(STS_INVALID, 1'b0);  dir_typed[19] = 1'b1;
        dir_rsp[20] = mk_rsp(STS_INVALID, 1'b0);  dir_typed[20] = 1'b1;

        // config phases: defaults, then extremes and a midpoint
        nx_set[0] = 1'b1; ue_set[0] = 64'h0000_8000_0000_0000;
        nx_set[1] = 1'b0; ue_set[1] = 64'h0001_0000_0000_0000;
        nx_set[2] = 1'b1; ue_set[2] = 64'h0;
        nx_set[3] = 1'b0; ue_set[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        nx_set[4] = 1'b1; ue_set[4] = 64'h0000_0100_0000_0000;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values are in force for the directed part
        for (int i = 0; i < N_DIR; i++) send_item(dir_req[i], dir_typed[i], dir_rsp[i]);

        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(CFG_NX_ENABLE, {63'd0, nx_set[ph]});
            write_cfg(CFG_USER_END, ue_set[ph]);
            for (int n = 0; n < RAND_ITEMS / 5; n++) begin
                // sender holds off once per phase until the pipe is empty
                if (n == RAND_ITEMS / 10) drain();
                send_item(rand_req(), 1'b0, '0);
            end
        end

        drain();
        if (pending_rsp.size() != 0) fail_cnt++;
        $display("Covered %0d results over 5 config phases: %0d maps ok, %0d ranges ok.",
                 rsp_cnt, ok_maps, ok_ranges);
        $display("Tables in use at end: %0d of %0d.", shadow_used, POOL);
        if (fail_cnt == 0) begin
            $display("[four_level_page_table_manager] OK");
        end else begin
            $display("[four_level_page_table_manager] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/fpt_pkg.sv
rtl/core/fpt_alu.sv
rtl/core/fpt_ram.sv
rtl/core/fpt_ctrl.sv
rtl/core/four_level_page_table_manager.sv
verif/tb.sv
